// ----- rtl/icbd_pkg.sv -----
// Package for the crop and box-filter downsampler: sizes, opcodes, helpers.
// No dependencies.
`default_nettype none
package icbd_pkg;
   localparam int IMG_WIDTH_DEF  = 300;
   localparam int IMG_HEIGHT_DEF = 300;
   localparam int GRID_MAX_DEF   = 64;
   localparam int CFG_W = 7;

   typedef enum logic [1:0] {
      OP_FRAME = 2'd0,
      OP_WRITE = 2'd1,
      OP_READ  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   localparam logic CSR_GRID_COLS = 1'b0;
   localparam logic CSR_GRID_ROWS = 1'b1;

   // gray level (11r + 16g + 5b) / 32
   function automatic logic [7:0] gray_of(input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b);
      logic [12:0] s;
      s = 13'(11 * r) + 13'(16 * g) + 13'(5 * b);
      return s[12:5];
   endfunction
endpackage
`default_nettype wire

// ----- rtl/icbd_if.sv -----
// Valid/ready channel interfaces for the downsampler.
// Depends on nothing.
`default_nettype none
interface icbd_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [8:0] pos_x;
   logic [8:0] pos_y;
   logic [7:0] red;
   logic [7:0] green;
   logic [7:0] blue;
   logic [5:0] cell_row;
   logic [5:0] cell_col;
   modport source (output valid, opcode, pos_x, pos_y, red, green, blue, cell_row,
                   cell_col, input ready);
   modport sink (input valid, opcode, pos_x, pos_y, red, green, blue, cell_row,
                 cell_col, output ready);
endinterface

interface icbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] tint;
   logic       empty_frame;
   modport source (output valid, tint, empty_frame, input ready);
   modport sink (input valid, tint, empty_frame, output ready);
endinterface

interface icbd_csr_if;
   logic       valid;
   logic       ready;
   logic       index;
   logic [6:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- rtl/icbd_ram.sv -----
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module icbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

// ----- rtl/icbd_div.sv -----
// Restoring divider, one quotient bit per cycle.
// No dependencies.
`default_nettype none
module icbd_div #(
   parameter int NW = 32,
   parameter int DW = 20
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          start,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic               done,
   output logic      [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);
   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   rem_ff, rem_in;
   logic [DW-1:0] den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   // shift one numerator bit in, subtract when it fits
   always_comb begin
      q_in = q_ff; rem_in = rem_ff; den_in = den_ff; cnt_in = cnt_ff;
      busy_in = busy_ff; done_in = 1'b0;
      trial = {rem_ff[DW-1:0], q_ff[NW-1]};
      if (start) begin
         q_in = num; rem_in = '0; den_in = den; cnt_in = CW'(NW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            q_in   = {q_ff[NW-2:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[NW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; rem_ff <= rem_in; den_ff <= den_in; cnt_ff <= cnt_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule
`default_nettype wire

// ----- rtl/ink_crop_block_downsampler.sv -----
// Top level of the crop and box-filter downsampler: sequencer, box tracker, store.
// Depends on icbd_pkg, icbd_if, icbd_ram, icbd_div.
//
//  channel | dir | handshake    | payload
//  req     | in  | valid/ready  | opcode, pos, rgb, cell
//  rsp     | out | valid/ready  | tint, empty_frame
//  csr     | in  | valid/ready  | index, data (grid_cols, grid_rows)
//
// Frame starts, pixel writes and empty-frame reads are taken in the idle state. A cell read
// runs the two block-size divisions on the shared divider (NW = 27), then scans the block
// pixels up to the image edge (at least one), passes a drain state, runs the mean division
// and loads the result register.
// Reset is synchronous; the store is not cleared. The result waits in an
// output register; req is not ready until it has been taken.
`default_nettype none
module ink_crop_block_downsampler
   import icbd_pkg::*;
#(
   parameter int IMG_WIDTH  = IMG_WIDTH_DEF,
   parameter int IMG_HEIGHT = IMG_HEIGHT_DEF,
   parameter int GRID_MAX   = GRID_MAX_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   icbd_req_if.sink  req,
   icbd_rsp_if.source rsp,
   icbd_csr_if.sink  csr
);
   localparam int DEPTH = IMG_WIDTH * IMG_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int YW    = $clog2(IMG_HEIGHT);
   localparam int GW    = $clog2(GRID_MAX + 1);
   localparam int EW    = 9;                 // extents and coordinates (9-bit fields)
   localparam int CW    = 16;                // block coordinate width
   localparam int SW    = 8 + 2 * EW + 1;    // block sum width
   localparam int NW    = SW;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_DIVH  = 7'b0000010,
      S_DIVW  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_DRAIN = 7'b0010000,
      S_MEAN  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [CFG_W-1:0] gcols_ff, grows_ff;
   logic [EW-1:0] top_ff, bot_ff, left_ff, right_ff;
   logic          ink_ff;
   logic [5:0]    crow_ff, ccol_ff;
   logic [EW:0]   bh_ff, bw_ff;
   logic [CW-1:0] y0_ff, x0_ff, y_ff, x_ff, yend_ff, xend_ff;
   logic [SW-1:0] sum_ff;
   logic [2*EW+1:0] area_ff;
   logic          acc_ff, acc_in;
   logic          rv_ff;
   logic [7:0]    tint_ff;
   logic          empty_ff;

   // clamp grid registers into 1..GRID_MAX
   function automatic logic [GW-1:0] clampg(input logic [CFG_W-1:0] v);
      if (v == '0) return GW'(1);
      if (int'(v) > GRID_MAX) return GW'(GRID_MAX);
      return GW'(v);
   endfunction

   logic acc_req, is_write, in_canvas, is_black;
   assign acc_req   = req.valid && req.ready;
   assign in_canvas = (int'(req.pos_x) < IMG_WIDTH) && (int'(req.pos_y) < IMG_HEIGHT);
   assign is_write  = acc_req && (op_type'(req.opcode) == OP_WRITE) && in_canvas;
   assign is_black  = (req.red == 8'd0) && (req.green == 8'd0) && (req.blue == 8'd0);
   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign csr.ready = 1'b1;

   // shared divider
   logic          dv_start, dv_done;
   logic [NW-1:0] dv_num, dv_quot;
   logic [2*EW+1:0] dv_den;
   icbd_div #(.NW(NW), .DW(2 * EW + 2)) u_div (
      .clock(clock), .reset(reset), .start(dv_start), .num(dv_num), .den(dv_den),
      .done(dv_done), .quot(dv_quot));

   // gray store
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]    rd_data;
   logic [CW+YW:0] rd_full;
   assign wr_addr = AW'(int'(req.pos_y) * IMG_WIDTH + int'(req.pos_x));
   assign rd_full = (CW + YW + 1)'(y_ff[YW-1:0] * IMG_WIDTH) + (CW + YW + 1)'(x_ff);
   assign rd_addr = AW'(rd_full);
   icbd_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
      .clock(clock), .wr_en(is_write),
      .wr_addr(wr_addr), .wr_data(gray_of(req.red, req.green, req.blue)),
      .rd_addr(rd_addr), .rd_data(rd_data));

   logic in_img, row_last, scan_done;
   assign in_img    = (int'(y_ff) < IMG_HEIGHT) && (int'(x_ff) < IMG_WIDTH);
   assign row_last  = (x_ff == xend_ff) || (int'(x_ff) >= IMG_WIDTH - 1);
   assign scan_done = row_last && ((y_ff == yend_ff) || (int'(y_ff) >= IMG_HEIGHT - 1));

   always_comb begin
      state_in = state_ff;
      dv_start = 1'b0;
      dv_num   = '0;
      dv_den   = '0;
      acc_in   = 1'b0;
      case (state_ff)
         S_IDLE: if (acc_req && op_type'(req.opcode) == OP_READ && ink_ff) begin
            state_in = S_DIVH; dv_start = 1'b1;
            dv_num = NW'(bot_ff - top_ff); dv_den = (2*EW+2)'(clampg(grows_ff));
         end
         S_DIVH: if (dv_done) begin
            state_in = S_DIVW; dv_start = 1'b1;
            dv_num = NW'(right_ff - left_ff); dv_den = (2*EW+2)'(clampg(gcols_ff));
         end
         S_DIVW: if (dv_done) state_in = S_SCAN;
         S_SCAN: begin
            acc_in = in_img;
            if (scan_done) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_MEAN; dv_start = 1'b1;
            dv_num = sum_ff + (acc_ff ? SW'(8'd255 - rd_data) : '0);
            dv_den = area_ff;
         end
         S_MEAN: if (dv_done) state_in = S_OUT;
         S_OUT: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         gcols_ff <= CFG_W'(28); grows_ff <= CFG_W'(28);
         top_ff <= '0; bot_ff <= '0; left_ff <= '0; right_ff <= '0;
         ink_ff <= 1'b0; rv_ff <= 1'b0; acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= acc_in;
         if (csr.valid) begin
            if (csr.index == CSR_GRID_COLS) gcols_ff <= csr.data;
            else grows_ff <= csr.data;
         end
         // bounding box of black pixels
         if (acc_req && op_type'(req.opcode) == OP_FRAME) begin
            ink_ff <= 1'b0; top_ff <= '0; bot_ff <= '0; left_ff <= '0; right_ff <= '0;
         end else if (is_write && is_black) begin
            ink_ff <= 1'b1;
            if (!ink_ff || req.pos_y < top_ff)   top_ff   <= req.pos_y;
            if (!ink_ff || req.pos_y > bot_ff)   bot_ff   <= req.pos_y;
            if (!ink_ff || req.pos_x < left_ff)  left_ff  <= req.pos_x;
            if (!ink_ff || req.pos_x > right_ff) right_ff <= req.pos_x;
         end
         // response register
         if (rsp.valid && rsp.ready) rv_ff <= 1'b0;
         if (acc_req && op_type'(req.opcode) == OP_READ && !ink_ff) begin
            rv_ff <= 1'b1; tint_ff <= 8'd0; empty_ff <= 1'b1;
         end
         if (state_ff == S_OUT) begin
            rv_ff <= 1'b1; tint_ff <= dv_quot[7:0]; empty_ff <= 1'b0;
         end
      end
      // block geometry and scan walk
      if (acc_req) begin
         crow_ff <= req.cell_row; ccol_ff <= req.cell_col;
      end
      if (state_ff == S_DIVH && dv_done) bh_ff <= (EW+1)'(dv_quot) + 1'b1;
      if (state_ff == S_DIVW && dv_done) begin
         bw_ff <= (EW+1)'(dv_quot) + 1'b1;
         y0_ff <= CW'(top_ff) + CW'(bh_ff) * CW'(crow_ff);
      end
      if (state_ff == S_DIVW && !dv_done) area_ff <= '0;
      if (state_ff == S_SCAN && y_ff == y0_ff && x_ff == x0_ff)
         area_ff <= (2*EW+2)'(bh_ff) * (2*EW+2)'(bw_ff);
      if (state_ff == S_DIVW && dv_done) begin
         sum_ff <= '0;
      end
      if (state_ff == S_DIVW && dv_done) begin
         x0_ff   <= CW'(left_ff) + CW'((EW+1)'(dv_quot + 1'b1)) * CW'(ccol_ff);
         x_ff    <= CW'(left_ff) + CW'((EW+1)'(dv_quot + 1'b1)) * CW'(ccol_ff);
         xend_ff <= CW'(left_ff) + CW'((EW+1)'(dv_quot + 1'b1)) * CW'(ccol_ff)
                    + CW'((EW+1)'(dv_quot)) ;
         y_ff    <= CW'(top_ff) + CW'(bh_ff) * CW'(crow_ff);
         yend_ff <= CW'(top_ff) + CW'(bh_ff) * CW'(crow_ff) + CW'(bh_ff) - 1'b1;
      end
      if (state_ff == S_SCAN) begin
         if (acc_ff) sum_ff <= sum_ff + SW'(8'd255 - rd_data);
         if (row_last) begin
            x_ff <= x0_ff; y_ff <= y_ff + 1'b1;
         end else begin
            x_ff <= x_ff + 1'b1;
         end
      end
   end

   assign rsp.valid       = rv_ff;
   assign rsp.tint        = tint_ff;
   assign rsp.empty_frame = empty_ff;
endmodule
`default_nettype wire

// ----- tb/icbd_tb_checker.sv -----
// Result checker for the crop and box-filter downsampler testbench.
// Watches the req, rsp and csr channels, predicts each cell mean and compares.
// Depends on icbd_pkg and icbd_if.
`default_nettype none
module icbd_tb_checker
   import icbd_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   icbd_req_if      req,
   icbd_rsp_if      rsp,
   icbd_csr_if      csr,
   output int       fail_count,
   output int       pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = IMG_WIDTH_DEF;
   localparam int H = IMG_HEIGHT_DEF;

   typedef struct packed {
      logic [7:0] tint;
      logic       empty_frame;
   } cell_result_type;

   // shadow copy of the block state
   logic [7:0]   gray_mem [0:W*H-1];
   int           top_row, bottom_row, left_col, right_col;
   bit           ink_seen;
   logic [6:0]   cols_reg, rows_reg;
   cell_result_type expected_cells [$];

   assign pending_count = expected_cells.size();

   function automatic int grid_size(logic [6:0] v);
      if (v == 0) return 1;
      if (v > GRID_MAX_DEF) return GRID_MAX_DEF;
      return int'(v);
   endfunction

   // truncated mean of (255 - gray) over one block; pixels off the image add 0
   function automatic logic [7:0] cell_mean(int row, int col);
      longint sum;
      longint bh, bw, y0, x0;
      sum = 0;
      bh = (bottom_row - top_row) / grid_size(rows_reg) + 1;
      bw = (right_col - left_col) / grid_size(cols_reg) + 1;
      y0 = top_row + bh * row;
      x0 = left_col + bw * col;
      for (longint y = y0; y < y0 + bh && y < H; y++) begin
         for (longint x = x0; x < x0 + bw && x < W; x++) begin
            sum += 255 - gray_mem[y * W + x];
         end
      end
      return 8'(sum / (bh * bw));
   endfunction

   always @(posedge clock) begin
      cell_result_type got, want;
      int px, py;
      if (reset) begin
         top_row = 0; bottom_row = 0; left_col = 0; right_col = 0;
         ink_seen = 0;
         cols_reg = 7'd28;
         rows_reg = 7'd28;
         expected_cells.delete();
         fail_count = 0;
      end else begin
         // grid register writes
         if (csr.valid && csr.ready) begin
            if (csr.index == CSR_GRID_COLS) cols_reg = csr.data;
            else rows_reg = csr.data;
         end
         // compare taken results against the oldest prediction
         if (rsp.valid && rsp.ready) begin
            got.tint = rsp.tint;
            got.empty_frame = rsp.empty_frame;
            if (expected_cells.size() == 0) begin
               $error("unexpected response tint=%0d empty_frame=%0d", got.tint,
                      got.empty_frame);
               fail_count = fail_count + 1;
            end else begin
               want = expected_cells.pop_front();
               if (got.tint !== want.tint) begin
                  $error("tint mismatch: expected %0d, actual %0d", want.tint, got.tint);
                  fail_count = fail_count + 1;
               end
               if (got.empty_frame !== want.empty_frame) begin
                  $error("empty_frame mismatch: expected %0d, actual %0d",
                         want.empty_frame, got.empty_frame);
                  fail_count = fail_count + 1;
               end
            end
         end
         // requests update the shadow state in order
         if (req.valid && req.ready) begin
            case (op_type'(req.opcode))
               OP_FRAME: begin
                  ink_seen = 0;
                  top_row = 0; bottom_row = 0; left_col = 0; right_col = 0;
               end
               OP_WRITE: begin
                  px = int'(req.pos_x);
                  py = int'(req.pos_y);
                  if (px < W && py < H) begin
                     gray_mem[py * W + px] =
                        8'((11 * int'(req.red) + 16 * int'(req.green)
                            + 5 * int'(req.blue)) / 32);
                     if (req.red == 0 && req.green == 0 && req.blue == 0) begin
                        if (!ink_seen) begin
                           top_row = py; bottom_row = py;
                           left_col = px; right_col = px;
                           ink_seen = 1;
                        end else begin
                           if (py < top_row) top_row = py;
                           if (py > bottom_row) bottom_row = py;
                           if (px < left_col) left_col = px;
                           if (px > right_col) right_col = px;
                        end
                     end
                  end
               end
               OP_READ: begin
                  if (!ink_seen) begin
                     want.tint = 8'd0;
                     want.empty_frame = 1'b1;
                  end else begin
                     want.tint = cell_mean(int'(req.cell_row), int'(req.cell_col));
                     want.empty_frame = 1'b0;
                  end
                  expected_cells.insert(expected_cells.size(), want);
               end
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench top for the crop and box-filter downsampler: clock, reset, stimulus,
// watchdog and verdict. Depends on icbd_pkg, icbd_if, icbd_tb_checker and the RTL.
`default_nettype none
module tb_top;
   import icbd_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int W = IMG_WIDTH_DEF;
   localparam int H = IMG_HEIGHT_DEF;
   localparam int FILL_LO = 280;            // first row and column of the painted corner
   localparam int FILL = W - FILL_LO;
   localparam int STALL_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count, pending_count;
   int   stall_cycles = 0;
   bit   calm = 1'b1;
   int   rsp_hold = 0;

   icbd_req_if req ();
   icbd_rsp_if rsp ();
   icbd_csr_if csr ();

   ink_crop_block_downsampler i_dut (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                                     .csr(csr));

   icbd_tb_checker i_checker (.clock(clock), .reset(reset), .req(req), .rsp(rsp),
                              .csr(csr), .fail_count(fail_count),
                              .pending_count(pending_count));

   always #10 clock = ~clock;

   // mostly short gaps, a few long ones, none in calm stretches
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp.ready = 1'b1;
         rsp_hold = pick_gap();
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
            stall_cycles <= 0;
         else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
         end else
            stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic send_req(op_type op, logic [8:0] x, logic [8:0] y, logic [7:0] r,
                           logic [7:0] g, logic [7:0] b, logic [5:0] crow, logic [5:0] ccol);
      int gap;
      req.valid = 1'b1;
      req.opcode = op;
      req.pos_x = x; req.pos_y = y;
      req.red = r; req.green = g; req.blue = b;
      req.cell_row = crow; req.cell_col = ccol;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic pixel(int x, int y, logic [7:0] r, logic [7:0] g, logic [7:0] b);
      send_req(OP_WRITE, 9'(x), 9'(y), r, g, b, 6'($urandom), 6'($urandom));
   endtask

   task automatic read_cell(int crow, int ccol);
      send_req(OP_READ, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 6'(crow), 6'(ccol));
   endtask

   task automatic new_frame();
      send_req(OP_FRAME, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom), 6'($urandom), 6'($urandom));
   endtask

   // hold off until every read has answered and the sequencer has settled
   task automatic drain();
      req.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [6:0] value);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data = value;
      @(posedge clock);
      while (!csr.ready) @(posedge clock);
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   // a random non-black color
   task automatic tinted(output logic [7:0] r, output logic [7:0] g, output logic [7:0] b);
      do begin
         r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
      end while (r == 0 && g == 0 && b == 0);
   endtask

   initial begin
      int cols_set [9] = '{64, 1, 0, 127, 7, 64, 1, 2, 28};
      int rows_set [9] = '{64, 1, 0, 100, 13, 1, 64, 2, 28};
      logic [7:0] r, g, b;
      int ext, ox, oy, gc, gr, n_items, roll;

      req.valid = 1'b0; req.opcode = OP_NONE;
      req.pos_x = '0; req.pos_y = '0; req.red = '0; req.green = '0; req.blue = '0;
      req.cell_row = '0; req.cell_col = '0;
      csr.valid = 1'b0; csr.index = CSR_GRID_COLS; csr.data = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // paint the lower right corner; black pixels only land there, so every
      // block read covers painted pixels or runs past the image edge
      calm = 1'b1;
      for (int y = FILL_LO; y < H; y++)
         for (int x = FILL_LO; x < W; x++) begin
            tinted(r, g, b);
            pixel(x, y, r, g, b);
         end
      calm = 1'b0;

      // directed: empty frame, extremes, off-canvas writes, unused opcode
      new_frame();
      read_cell(0, 0);
      pixel(FILL_LO, FILL_LO, 8'd0, 8'd0, 8'd0);
      read_cell(0, 0);
      pixel(299, 299, 8'd0, 8'd0, 8'd0);
      pixel(290, 290, 8'd255, 8'd255, 8'd255);
      pixel(511, 10, 8'd0, 8'd0, 8'd0);
      pixel(10, 300, 8'd0, 8'd0, 8'd0);
      pixel(511, 511, 8'd0, 8'd0, 8'd0);
      send_req(OP_NONE, 9'h1ff, 9'h1ff, 8'hff, 8'hff, 8'hff, 6'h3f, 6'h3f);
      read_cell(0, 0);
      read_cell(27, 27);
      read_cell(27, 0);
      read_cell(28, 28);
      read_cell(63, 63);
      // black pixel overwritten keeps the box
      pixel(299, 299, 8'd255, 8'd0, 8'd0);
      read_cell(27, 27);
      new_frame();
      pixel(285, 290, 8'd0, 8'd0, 8'd0);
      read_cell(0, 0);
      read_cell(1, 1);

      // random phases over several grid settings
      for (int ph = 0; ph < 9; ph++) begin
         drain();
         csr_write(CSR_GRID_COLS, 7'(cols_set[ph]));
         csr_write(CSR_GRID_ROWS, 7'(rows_set[ph]));
         gc = (cols_set[ph] == 0) ? 1 : (cols_set[ph] > 64 ? 64 : cols_set[ph]);
         gr = (rows_set[ph] == 0) ? 1 : (rows_set[ph] > 64 ? 64 : rows_set[ph]);
         n_items = 0;
         while (n_items < 50) begin
            calm = ($urandom_range(0, 3) == 0);
            // box somewhere inside the painted corner
            ext = $urandom_range(0, FILL - 1);
            ox = FILL_LO + $urandom_range(0, FILL - 1 - ext);
            oy = FILL_LO + $urandom_range(0, FILL - 1 - ext);
            new_frame();
            n_items++;
            if ($urandom_range(0, 9) == 0) begin
               read_cell($urandom_range(0, 63), $urandom_range(0, 63));
               n_items++;
            end
            for (int k = $urandom_range(8, 25); k > 0; k--) begin
               roll = $urandom_range(0, 99);
               if (roll < 45) pixel(ox + $urandom_range(0, ext), oy + $urandom_range(0, ext),
                                    8'd0, 8'd0, 8'd0);
               else if (roll < 75) begin
                  tinted(r, g, b);
                  pixel(ox + $urandom_range(0, ext), oy + $urandom_range(0, ext), r, g, b);
               end else if (roll < 85) begin
                  tinted(r, g, b);
                  pixel($urandom_range(0, W - 1), $urandom_range(0, H - 1), r, g, b);
               end else if (roll < 90) begin
                  if ($urandom_range(0, 1)) pixel($urandom_range(W, 511), $urandom_range(0, 511),
                                                  8'($urandom), 8'($urandom), 8'($urandom));
                  else pixel($urandom_range(0, 511), $urandom_range(H, 511),
                             8'($urandom), 8'($urandom), 8'($urandom));
               end else if (roll < 92) begin
                  send_req(OP_NONE, 9'($urandom), 9'($urandom), 8'($urandom), 8'($urandom),
                           8'($urandom), 6'($urandom), 6'($urandom));
                  continue;
               end else begin
                  // cells mostly inside the grid, some past it
                  if ($urandom_range(0, 4) == 0)
                     read_cell($urandom_range(0, 63), $urandom_range(0, 63));
                  else read_cell($urandom_range(0, gr - 1), $urandom_range(0, gc - 1));
               end
               n_items++;
            end
            read_cell($urandom_range(0, gr - 1), $urandom_range(0, gc - 1));
            n_items++;
         end
      end

      // wind down
      req.valid = 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (50) @(negedge clock);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/icbd_pkg.sv
rtl/icbd_if.sv
rtl/icbd_ram.sv
rtl/icbd_div.sv
rtl/ink_crop_block_downsampler.sv
tb/icbd_tb_checker.sv
tb/tb_top.sv
